// ----- rtl/pps_pkg.sv -----
// Package with the slot record type, result codes and shared arithmetic helpers.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  localparam logic       OP_ARRIVE = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  localparam logic [2:0] KIND_ACCEPTED = 3'd0;
  localparam logic [2:0] KIND_REJECTED = 3'd1;
  localparam logic [2:0] KIND_IDLE     = 3'd2;
  localparam logic [2:0] KIND_RAN      = 3'd3;
  localparam logic [2:0] KIND_FINISHED = 3'd4;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [7:0]  priority_lvl;
    logic        started;
    logic [15:0] stop_time;
    logic [15:0] wait_sum;
    logic [15:0] response;
    logic [15:0] context_sum;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id_res;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic [15:0] response;
    logic [15:0] now;
  } result_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? SAT16 : s[15:0];
  endfunction

  // Bookkeeping done when a slot is given the processor.
  function automatic slot_rec_t dispatch_rec(input slot_rec_t rec, input logic [15:0] now);
    slot_rec_t r;
    r = rec;
    if (rec.started) begin
      r.wait_sum = sat_add16(rec.wait_sum, now - rec.stop_time);
    end else begin
      r.response = now - rec.arrival;
      r.wait_sum = sat_add16(rec.wait_sum, now - rec.arrival);
      r.started  = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pps_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface pps_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  task_id;
  logic [15:0] burst_length;
  logic [7:0]  task_priority;
  modport source (output valid, op, task_id, burst_length, task_priority, input ready);
  modport sink (input valid, op, task_id, burst_length, task_priority, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  task_id_res;
  logic [15:0] turnaround;
  logic [15:0] waiting;
  logic [15:0] response;
  logic [15:0] now;
  modport source (output valid, kind, task_id_res, turnaround, waiting, response, now,
                  input ready);
  modport sink (input valid, kind, task_id_res, turnaround, waiting, response, now,
                output ready);
endinterface

interface pps_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
// An arrival transaction writes the record into the lowest free slot in the accept cycle and
// then posts the result from ST_POST once the output is free. A tick transaction reads the
// slot memory one entry per cycle to find the best ready task and the running task's record,
// then writes back the preempted record (ST_DECIDE) and the running record (ST_EXEC) through
// the single write port; when no task is ready it goes from ST_DECIDE straight to ST_POST.
// One transaction is worked on at a time; a new one is accepted while the previous result
// waits at the output.
module preemptive_priority_scheduler #(
  parameter int SLOTS = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pps_in_if.sink     in_ch,
  pps_out_if.source  out_ch,
  pps_cfg_if.sink    cfg_ch
);
  import pps_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_EXEC, ST_POST} state_t;

  state_t          state_r;
  logic [7:0]      cost_r;
  logic [15:0]     now_r;
  logic [IW-1:0]   run_slot_r;
  logic            run_valid_r;
  logic [SLOTS-1:0] slot_valid_r;
  logic [CW-1:0]   cnt_r;
  logic            pend_r;
  logic [IW-1:0]   pend_idx_r;
  logic            found_r;
  logic [IW-1:0]   best_idx_r;
  slot_rec_t       best_rec_r;
  slot_rec_t       run_rec_r;
  slot_rec_t       act_rec_r;
  result_t         res_r;
  logic            out_valid_r;
  result_t         out_r;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  slot_rec_t       mem_wdata;
  logic [IW-1:0]   mem_raddr;
  slot_rec_t       mem_rdata;

  logic            free_found;
  logic [IW-1:0]   free_idx;
  logic            in_fire;
  logic            preempt;
  slot_rec_t       arr_rec;
  slot_rec_t       old_run_rec;
  slot_rec_t       exec_rec;
  logic [15:0]     now_inc;

  pps_slot_ram #(.DEPTH(SLOTS), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.task_id_res = out_r.task_id_res;
  assign out_ch.turnaround  = out_r.turnaround;
  assign out_ch.waiting     = out_r.waiting;
  assign out_ch.response    = out_r.response;
  assign out_ch.now         = out_r.now;

  assign now_inc   = now_r + 16'd1;
  assign mem_raddr = cnt_r[IW-1:0];
  assign preempt   = run_valid_r && found_r && (best_rec_r.priority_lvl > run_rec_r.priority_lvl);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    arr_rec              = '0;
    arr_rec.task_id      = in_ch.task_id;
    arr_rec.arrival      = now_r;
    arr_rec.remaining    = in_ch.burst_length;
    arr_rec.priority_lvl = in_ch.task_priority;

    old_run_rec             = run_rec_r;
    old_run_rec.context_sum = sat_add16(run_rec_r.context_sum, {8'd0, cost_r});
    old_run_rec.stop_time   = now_r;

    exec_rec           = act_rec_r;
    exec_rec.remaining = act_rec_r.remaining - 16'd1;

    mem_we    = 1'b0;
    mem_waddr = run_slot_r;
    mem_wdata = exec_rec;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.op == OP_ARRIVE && in_ch.burst_length != 16'd0 && free_found) begin
          mem_we    = 1'b1;
          mem_waddr = free_idx;
          mem_wdata = arr_rec;
        end
      end
      ST_DECIDE: begin
        if (preempt) begin
          mem_we    = 1'b1;
          mem_waddr = run_slot_r;
          mem_wdata = old_run_rec;
        end
      end
      ST_EXEC: begin
        mem_we = (exec_rec.remaining != 16'd0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cost_r       <= '0;
      now_r        <= '0;
      run_slot_r   <= '0;
      run_valid_r  <= 1'b0;
      slot_valid_r <= '0;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cost_r <= cfg_ch.data;
      end
      if (out_valid_r && out_ch.ready && state_r != ST_POST) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.op == OP_ARRIVE) begin
              res_r <= '{kind: (in_ch.burst_length != 16'd0 && free_found) ?
                               KIND_ACCEPTED : KIND_REJECTED,
                         task_id_res: in_ch.task_id,
                         turnaround: 16'd0, waiting: 16'd0, response: 16'd0, now: now_r};
              if (in_ch.burst_length != 16'd0 && free_found) begin
                slot_valid_r[free_idx] <= 1'b1;
              end
              state_r <= ST_POST;
            end else begin
              cnt_r   <= '0;
              pend_r  <= 1'b0;
              found_r <= 1'b0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_r     <= (cnt_r < CW'(SLOTS));
          pend_idx_r <= cnt_r[IW-1:0];
          if (cnt_r < CW'(SLOTS)) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (pend_r && slot_valid_r[pend_idx_r]) begin
            if (run_valid_r && pend_idx_r == run_slot_r) begin
              run_rec_r <= mem_rdata;
            end else if (!found_r || mem_rdata.priority_lvl > best_rec_r.priority_lvl) begin
              found_r    <= 1'b1;
              best_idx_r <= pend_idx_r;
              best_rec_r <= mem_rdata;
            end
          end
          if (cnt_r == CW'(SLOTS) && !pend_r) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (preempt || (!run_valid_r && found_r)) begin
            act_rec_r   <= dispatch_rec(best_rec_r, now_r);
            run_slot_r  <= best_idx_r;
            run_valid_r <= 1'b1;
            state_r     <= ST_EXEC;
          end else if (run_valid_r) begin
            act_rec_r <= run_rec_r;
            state_r   <= ST_EXEC;
          end else begin
            now_r   <= now_inc;
            res_r   <= '{kind: KIND_IDLE, task_id_res: 8'd0, turnaround: 16'd0,
                         waiting: 16'd0, response: 16'd0, now: now_inc};
            state_r <= ST_POST;
          end
        end
        ST_EXEC: begin
          now_r <= now_inc;
          if (exec_rec.remaining == 16'd0) begin
            slot_valid_r[run_slot_r] <= 1'b0;
            run_valid_r              <= 1'b0;
            res_r <= '{kind: KIND_FINISHED, task_id_res: act_rec_r.task_id,
                       turnaround: sat_add16(now_inc - act_rec_r.arrival, act_rec_r.context_sum),
                       waiting: sat_add16(act_rec_r.wait_sum, act_rec_r.context_sum),
                       response: act_rec_r.response, now: now_inc};
          end else begin
            res_r <= '{kind: KIND_RAN, task_id_res: act_rec_r.task_id, turnaround: 16'd0,
                       waiting: 16'd0, response: 16'd0, now: now_inc};
          end
          state_r <= ST_POST;
        end
        ST_POST: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The running slot always holds a live task.
  a_run_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> slot_valid_r[run_slot_r])
    else $error("running slot is not valid");

  // Only one transaction is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  // Time advances only at the end of tick processing.
  a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (now_r != $past(now_r)) |-> ($past(state_r) == ST_EXEC || $past(state_r) == ST_DECIDE))
    else $error("time advanced outside a tick");

  // A finished result is never reported while the task is still marked running.
  a_finish_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST && res_r.kind == KIND_FINISHED) |-> !run_valid_r)
    else $error("finished task still running");
`endif

endmodule
`default_nettype wire

// ----- rtl/pps_slot_ram.sv -----
// Slot record memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pps_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  pps_pkg::slot_rec_t      wdata,
  input  wire logic [AW-1:0]      raddr,
  output pps_pkg::slot_rec_t      rdata
);
  import pps_pkg::*;

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- test/tb_pps_checker.sv -----
// Checker that predicts scheduler results from observed transactions and compares them.
`timescale 1ns / 1ps
`default_nettype none
module tb_pps_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  pps_in_if         in_mon,
  pps_out_if        out_mon,
  pps_cfg_if        cfg_mon,
  output int        fail_count,
  output int        pending
);
  import pps_pkg::*;

  localparam int NSLOT = 16;

  logic        sv_valid [NSLOT];
  logic [7:0]  sv_id [NSLOT];
  logic [15:0] sv_arr [NSLOT];
  logic [15:0] sv_rem [NSLOT];
  logic [7:0]  sv_prio [NSLOT];
  logic        sv_started [NSLOT];
  logic [15:0] sv_stop [NSLOT];
  logic [15:0] sv_wait [NSLOT];
  logic [15:0] sv_resp [NSLOT];
  logic [15:0] sv_ctx [NSLOT];
  logic [15:0] sched_time;
  int          run_slot;
  logic        run_valid;
  logic [7:0]  switch_cost;
  result_t     expected_results[$];

  function automatic logic [15:0] sum_sat(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  task automatic give_cpu(input int s);
    logic [15:0] d;
    if (sv_started[s]) begin
      sv_wait[s] = sum_sat(sv_wait[s], sched_time - sv_stop[s]);
    end else begin
      d = sched_time - sv_arr[s];
      sv_resp[s] = d;
      sv_wait[s] = sum_sat(sv_wait[s], d);
      sv_started[s] = 1'b1;
    end
    run_slot = s;
    run_valid = 1'b1;
  endtask

  task automatic schedule_item(input logic op, input logic [7:0] id,
                               input logic [15:0] burst, input logic [7:0] prio);
    result_t r;
    int fs;
    int cand;
    r = '0;
    fs = -1;
    cand = -1;
    if (op == OP_ARRIVE) begin
      for (int i = NSLOT - 1; i >= 0; i--) if (!sv_valid[i]) fs = i;
      r.task_id_res = id;
      if (burst == 0 || fs < 0) begin
        r.kind = KIND_REJECTED;
      end else begin
        sv_valid[fs] = 1'b1; sv_id[fs] = id; sv_arr[fs] = sched_time;
        sv_rem[fs] = burst; sv_prio[fs] = prio; sv_started[fs] = 1'b0;
        sv_stop[fs] = '0; sv_wait[fs] = '0; sv_resp[fs] = '0; sv_ctx[fs] = '0;
        r.kind = KIND_ACCEPTED;
      end
    end else begin
      for (int i = 0; i < NSLOT; i++) begin
        if (!sv_valid[i] || (run_valid && i == run_slot)) continue;
        if (cand < 0 || sv_prio[i] > sv_prio[cand]) cand = i;
      end
      if (!run_valid) begin
        if (cand >= 0) give_cpu(cand);
      end else if (cand >= 0 && sv_prio[cand] > sv_prio[run_slot]) begin
        sv_ctx[run_slot] = sum_sat(sv_ctx[run_slot], {8'd0, switch_cost});
        sv_stop[run_slot] = sched_time;
        run_valid = 1'b0;
        give_cpu(cand);
      end
      sched_time = sched_time + 16'd1;
      if (!run_valid) begin
        r.kind = KIND_IDLE;
      end else begin
        r.task_id_res = sv_id[run_slot];
        sv_rem[run_slot] = sv_rem[run_slot] - 16'd1;
        if (sv_rem[run_slot] == 0) begin
          r.turnaround = sum_sat(sched_time - sv_arr[run_slot], sv_ctx[run_slot]);
          r.waiting = sum_sat(sv_wait[run_slot], sv_ctx[run_slot]);
          r.response = sv_resp[run_slot];
          sv_valid[run_slot] = 1'b0;
          run_valid = 1'b0;
          r.kind = KIND_FINISHED;
        end else begin
          r.kind = KIND_RAN;
        end
      end
    end
    r.now = sched_time;
    expected_results = {expected_results, r};
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) sv_valid[i] = 1'b0;
      sched_time = '0;
      run_slot = 0;
      run_valid = 1'b0;
      switch_cost = '0;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) switch_cost = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        schedule_item(in_mon.op, in_mon.task_id, in_mon.burst_length, in_mon.task_priority);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction, kind %0d", out_mon.kind);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_mon.kind !== e.kind ||
              out_mon.task_id_res !== e.task_id_res ||
              out_mon.turnaround !== e.turnaround ||
              out_mon.waiting !== e.waiting ||
              out_mon.response !== e.response ||
              out_mon.now !== e.now) begin
            if (out_mon.kind !== e.kind)
              $error("kind expected %0d actual %0d", e.kind, out_mon.kind);
            if (out_mon.task_id_res !== e.task_id_res)
              $error("task_id_res expected %0d actual %0d", e.task_id_res, out_mon.task_id_res);
            if (out_mon.turnaround !== e.turnaround)
              $error("turnaround expected %0d actual %0d", e.turnaround, out_mon.turnaround);
            if (out_mon.waiting !== e.waiting)
              $error("waiting expected %0d actual %0d", e.waiting, out_mon.waiting);
            if (out_mon.response !== e.response)
              $error("response expected %0d actual %0d", e.response, out_mon.response);
            if (out_mon.now !== e.now)
              $error("now expected %0d actual %0d", e.now, out_mon.now);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import pps_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  logic long_hold = 1'b0;
  logic hold_request = 1'b0;
  logic hold_done = 1'b0;
  int   item_budget;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();
  pps_cfg_if cfg_ch ();

  preemptive_priority_scheduler #(.SLOTS(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tb_pps_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  // Receiver: its own stall pattern plus one long hold-off on request.
  always @(posedge clk) begin
    if (long_hold) out_ch.ready <= 1'b0;
    else if (($urandom % 64) < 16) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      long_hold <= 1'b1;
      repeat (400) @(posedge clk);
      long_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [7:0] id,
                           input logic [15:0] burst, input logic [7:0] prio);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.task_id <= id;
    in_ch.burst_length <= burst;
    in_ch.task_priority <= prio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sender idles for a random gap, possibly none, between bursts.
  task automatic burst_gap();
    int g;
    g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cost(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item(input int mode);
    logic [15:0] b;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) b = 16'd0;
    else if (r < 7) b = 16'($urandom);
    else if (mode == 0) b = 16'($urandom_range(1, 6));
    else b = 16'($urandom_range(1, 40));
    if ($urandom_range(0, 99) < 45)
      send_item(OP_ARRIVE, 8'($urandom), b,
                (r < 50) ? 8'($urandom_range(0, 3)) : 8'($urandom));
    else
      send_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int blen;
    in_ch.valid = 1'b0;
    in_ch.op = OP_ARRIVE;
    in_ch.task_id = '0;
    in_ch.burst_length = '0;
    in_ch.task_priority = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: an idle tick on an empty table, zero burst, field extremes.
    send_item(OP_TICK, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(OP_ARRIVE, 8'hAA, 16'd0, 8'd5);
    send_item(OP_ARRIVE, 8'h00, 16'd1, 8'd0);
    send_item(OP_TICK, 8'h00, 16'h0000, 8'h00);
    drain();
    write_cost(8'd255);
    // Preemption with a maximum context cost and a tie between equal priorities.
    send_item(OP_ARRIVE, 8'h11, 16'd4, 8'd10);
    send_item(OP_TICK, 8'h00, 16'h0, 8'h0);
    send_item(OP_ARRIVE, 8'h22, 16'd2, 8'd200);
    send_item(OP_ARRIVE, 8'h33, 16'd2, 8'd200);
    send_item(OP_ARRIVE, 8'h44, 16'd1, 8'd10);
    for (int i = 0; i < 8; i++) send_item(OP_TICK, 8'h55, 16'hAAAA, 8'h55);
    // Fill the table so that the next arrival is rejected.
    for (int i = 0; i < 17; i++) send_item(OP_ARRIVE, 8'(i), 16'hFFFF, 8'hFF);
    drain();
    rst_n <= rst_n;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_cost(8'd0);
        1: write_cost(8'd3);
        2: write_cost(8'($urandom));
        default: write_cost(8'd255);
      endcase
      item_budget = 360;
      while (item_budget > 0) begin
        blen = $urandom_range(1, 30);
        for (int k = 0; k < blen && item_budget > 0; k++) begin
          if (phase == 1 && item_budget == 200) hold_request <= 1'b1;
          random_item(phase & 1);
          item_budget--;
        end
        burst_gap();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- preemptive_priority_scheduler.f -----
rtl/pps_pkg.sv
rtl/pps_if.sv
rtl/pps_slot_ram.sv
rtl/preemptive_priority_scheduler.sv
test/tb_pps_checker.sv
test/tb_top.sv
